/* src/size_tiered_compaction_select_defines.svh */
// Assertion macros for the size-tiered compaction selector.
// No dependencies; expects signals named clock and reset in the including scope.
`ifndef SIZE_TIERED_COMPACTION_SELECT_DEFINES_SVH
`define SIZE_TIERED_COMPACTION_SELECT_DEFINES_SVH

// Condition must never hold outside reset
`define STCS_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define STCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/stcs_pkg.sv */
// Shared types and constants for the size-tiered compaction selector.
// No dependencies.
package stcs_pkg;

   localparam int TABLES = 32;
   localparam int IDX_W  = $clog2(TABLES);
   localparam int CNT_W  = $clog2(TABLES + 1);
   localparam int ID_W   = 16;
   localparam int SIZE_W = 48;
   localparam int HALF_W = SIZE_W / 2;
   localparam int MULT_W = 16;
   localparam int PROD_W = SIZE_W + MULT_W;

   localparam logic [MULT_W-1:0] ONE_Q8 = 16'd256;

   // Configuration register indexes
   localparam logic [1:0] REG_MIN_TABLES = 2'd0;
   localparam logic [1:0] REG_BUCKET_HIGH = 2'd1;
   localparam logic [1:0] REG_BUCKET_LOW = 2'd2;

   typedef enum logic [1:0] {
      ST_SELECTED = 2'd0,
      ST_NONE     = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_DECIDE,
      S_RANK_RD,
      S_RANK_CMP,
      S_RANK_WR,
      S_SCAN_BASE,
      S_SCAN_MUL,
      S_SCAN_MUL_HI,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SCAN_CHK,
      S_EMIT_RD,
      S_EMIT_SET,
      S_OUT_WAIT
   } state_type;

endpackage

/* src/size_tiered_compaction_select.sv */
// Size-tiered compaction selector: loads one (id, size) transaction per cycle into
// a 32-entry table store while in its load state. The marked final transaction
// starts the selection: a rank pass (each entry compared against every entry with
// one shared comparator) writes the stable size order, then a window scan (a 48x16
// bound per start entry, built from its low and high 24x16 halves on one shared
// multiplier, then one compare per following entry) finds the first bucket, and its
// ids go out one per response. Overflow, too few tables, invalid multipliers or no
// bucket give a single status response instead. req_ready stays low from the final
// transaction until the last response is taken.
// Depends on stcs_pkg and size_tiered_compaction_select_defines.svh.
module size_tiered_compaction_select (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [stcs_pkg::ID_W-1:0]   req_table_id,
   input  logic [stcs_pkg::SIZE_W-1:0] req_size_bytes,
   input  logic                        req_last_table,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [stcs_pkg::ID_W-1:0]   rsp_chosen_id,
   output logic                        rsp_last_result,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_write_data
);
   import stcs_pkg::*;
   `include "size_tiered_compaction_select_defines.svh"

   // Table stores: arrival order and sorted order
   logic [ID_W-1:0]   hld_id_mem [TABLES];
   logic [SIZE_W-1:0] hld_size_mem [TABLES];
   logic [ID_W-1:0]   srt_id_mem [TABLES];
   logic [SIZE_W-1:0] srt_size_mem [TABLES];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        min_ff;
   logic [MULT_W-1:0] high_ff, low_ff;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in, rank_ff, rank_in, run_ff, run_in, k_ff, k_in;
   logic [PROD_W-1:0] bound_ff, bound_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;

   // Memory ports
   logic              hld_we, srt_we;
   logic [IDX_W-1:0]  hld_addr_a, hld_addr_b, srt_addr;
   logic [ID_W-1:0]   hld_id_a_ff, srt_id_ff;
   logic [SIZE_W-1:0] hld_size_a_ff, hld_size_b_ff, srt_size_ff;
   logic [CNT_W-1:0]  emit_idx;
   logic              mult_bad;

   // Shared multiplier: one half of a size times the high multiplier
   logic [HALF_W-1:0]        mul_a;
   logic [HALF_W+MULT_W-1:0] mul_p;

   assign mult_bad = (low_ff >= high_ff) || (low_ff <= ONE_Q8);
   assign emit_idx = i_ff + k_ff;
   assign mul_p    = {{MULT_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, high_ff};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= 8'd4;
         high_ff <= 16'd384;
         low_ff  <= 16'd320;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_TABLES:  min_ff  <= csr_write_data[7:0];
            REG_BUCKET_HIGH: high_ff <= csr_write_data;
            REG_BUCKET_LOW:  low_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Memories: one write port, registered reads
   always_ff @(posedge clock) begin
      if (hld_we) begin
         hld_id_mem[count_ff[IDX_W-1:0]]   <= req_table_id;
         hld_size_mem[count_ff[IDX_W-1:0]] <= req_size_bytes;
      end
      hld_id_a_ff   <= hld_id_mem[hld_addr_a];
      hld_size_a_ff <= hld_size_mem[hld_addr_a];
      hld_size_b_ff <= hld_size_mem[hld_addr_b];
   end

   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_id_mem[rank_ff[IDX_W-1:0]]   <= hld_id_a_ff;
         srt_size_mem[rank_ff[IDX_W-1:0]] <= hld_size_a_ff;
      end
      srt_id_ff   <= srt_id_mem[srt_addr];
      srt_size_ff <= srt_size_mem[srt_addr];
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      rank_ff       <= rank_in;
      run_ff        <= run_in;
      k_ff          <= k_in;
      bound_ff      <= bound_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      run_in        = run_ff;
      k_in          = k_ff;
      bound_in      = bound_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      hld_we        = 1'b0;
      srt_we        = 1'b0;
      hld_addr_a    = i_ff[IDX_W-1:0];
      hld_addr_b    = j_ff[IDX_W-1:0];
      srt_addr      = j_ff[IDX_W-1:0];
      mul_a         = srt_size_ff[HALF_W-1:0];
      req_ready     = 1'b0;

      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CNT_W'(TABLES)) begin
                  hld_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_table) state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_id_in   = '0;
            rsp_last_in = 1'b1;
            i_in        = '0;
            j_in        = '0;
            rank_in     = '0;
            if (ovf_ff) begin
               rsp_status_in = ST_OVERFLOW;
               rsp_valid_in  = 1'b1;
               state_in      = S_OUT_WAIT;
            end else if ({2'b0, count_ff} < min_ff) begin
               rsp_status_in = ST_NONE;
               rsp_valid_in  = 1'b1;
               state_in      = S_OUT_WAIT;
            end else if (mult_bad) begin
               rsp_status_in = ST_INVALID;
               rsp_valid_in  = 1'b1;
               state_in      = S_OUT_WAIT;
            end else begin
               state_in = S_RANK_RD;
            end
         end
         // Rank: count entries that sort ahead of entry i
         S_RANK_RD: state_in = S_RANK_CMP;
         S_RANK_CMP: begin
            if ((hld_size_b_ff < hld_size_a_ff) ||
                (hld_size_b_ff == hld_size_a_ff && j_ff < i_ff))
               rank_in = rank_ff + 1'b1;
            j_in = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == count_ff) ? S_RANK_WR : S_RANK_RD;
         end
         S_RANK_WR: begin
            srt_we  = 1'b1;
            i_in    = i_ff + 1'b1;
            j_in    = '0;
            rank_in = '0;
            if (i_ff + 1'b1 == count_ff) begin
               i_in     = '0;
               state_in = S_SCAN_BASE;
            end else begin
               state_in = S_RANK_RD;
            end
         end
         // Scan: window starting at sorted entry i
         S_SCAN_BASE: begin
            srt_addr = i_ff[IDX_W-1:0];
            state_in = S_SCAN_MUL;
         end
         // Bound = size * high, low half of the size first
         S_SCAN_MUL: begin
            srt_addr = i_ff[IDX_W-1:0];
            bound_in = {{(PROD_W-HALF_W-MULT_W){1'b0}}, mul_p};
            run_in   = CNT_W'(1);
            j_in     = i_ff + 1'b1;
            state_in = S_SCAN_MUL_HI;
         end
         S_SCAN_MUL_HI: begin
            mul_a    = srt_size_ff[SIZE_W-1:HALF_W];
            bound_in = bound_ff + {mul_p, {HALF_W{1'b0}}};
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = (j_ff == count_ff) ? S_SCAN_CHK : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if ({8'b0, srt_size_ff, 8'b0} <= bound_ff) begin
               run_in   = run_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if ({2'b0, run_ff} >= min_ff) begin
               k_in     = '0;
               state_in = S_EMIT_RD;
            end else if (i_ff + 1'b1 == count_ff) begin
               rsp_status_in = ST_NONE;
               rsp_id_in     = '0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_OUT_WAIT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SCAN_BASE;
            end
         end
         // Emission of the bucket ids in sorted order
         S_EMIT_RD: begin
            srt_addr = emit_idx[IDX_W-1:0];
            state_in = S_EMIT_SET;
         end
         S_EMIT_SET: begin
            rsp_status_in = ST_SELECTED;
            rsp_id_in     = srt_id_ff;
            rsp_last_in   = (k_ff + 1'b1 == run_ff);
            rsp_valid_in  = 1'b1;
            state_in      = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_id   = rsp_id_ff;
   assign rsp_last_result = rsp_last_ff;

   // Checks
   `STCS_ASSERT_NEVER(a_no_overlap, req_ready && rsp_valid, "load while result pending")
   `STCS_ASSERT_NEVER(a_count_cap, count_ff > CNT_W'(TABLES), "held count beyond capacity")
   `STCS_ASSERT_NEXT(a_reload, rsp_valid & rsp_ready & rsp_last_result, req_ready, "no reload")
   `STCS_ASSERT_NEXT(a_start, req_valid & req_ready & req_last_table, !req_ready, "no start")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for size_tiered_compaction_select.
// Loads table batches, predicts each bucket selection and checks every response.
// Depends on stcs_pkg and the selector RTL.
module tb_top;
   import stcs_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int WATCH_LIMIT = 40000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
      logic              last;
   } table_item_type;

   typedef struct {
      status_type      status;
      logic [ID_W-1:0] id;
      logic            last;
   } pick_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [ID_W-1:0]   req_table_id;
   logic [SIZE_W-1:0] req_size_bytes;
   logic              req_last_table;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_chosen_id;
   logic              rsp_last_result;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [15:0]       csr_write_data;

   size_tiered_compaction_select dut (.*);

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow configuration and batch store of the predictor
   logic [7:0]        min_cfg;
   logic [MULT_W-1:0] high_cfg;
   logic [MULT_W-1:0] low_cfg;
   logic [ID_W-1:0]   held_id[TABLES];
   logic [SIZE_W-1:0] held_size[TABLES];
   int                held_n;
   bit                held_over;

   table_item_type tables_q[$];
   pick_type       picks_q[$];
   int          offered;
   int          accepted;
   int          picks_seen;
   int          errors;
   int          batches;
   int          sender_burst;

   // Append one expected response
   function automatic void queue_pick(input status_type s, input logic [ID_W-1:0] id,
                                      input logic last);
      pick_type p;
      p.status = s;
      p.id = id;
      p.last = last;
      picks_q.insert(picks_q.size(), p);
   endfunction

   // Predict the responses for the batch just closed
   function automatic void predict_picks();
      logic [ID_W-1:0]   ids[TABLES];
      logic [SIZE_W-1:0] sz[TABLES];
      logic [ID_W-1:0]   kid;
      logic [SIZE_W-1:0] ks;
      logic [63:0]       bound;
      int                i, j, run, cnt;
      if (held_over) begin
         queue_pick(ST_OVERFLOW, '0, 1'b1);
         return;
      end
      if (held_n < int'(min_cfg)) begin
         queue_pick(ST_NONE, '0, 1'b1);
         return;
      end
      if (low_cfg >= high_cfg || low_cfg <= ONE_Q8) begin
         queue_pick(ST_INVALID, '0, 1'b1);
         return;
      end
      for (i = 0; i < held_n; i++) begin
         ids[i] = held_id[i];
         sz[i] = held_size[i];
      end
      // stable insertion sort on size
      for (i = 1; i < held_n; i++) begin
         kid = ids[i];
         ks = sz[i];
         j = i;
         while (j > 0 && sz[j-1] > ks) begin
            ids[j] = ids[j-1];
            sz[j] = sz[j-1];
            j--;
         end
         ids[j] = kid;
         sz[j] = ks;
      end
      // first window that reaches the minimum
      for (i = 0; i < held_n; i++) begin
         bound = 64'(sz[i]) * 64'(high_cfg);
         run = 1;
         for (j = i + 1; j < held_n; j++) begin
            if ((64'(sz[j]) << 8) <= bound) run++;
            else break;
         end
         if (run >= int'(min_cfg)) begin
            cnt = (run > TABLES) ? TABLES : run;
            for (j = 0; j < cnt; j++)
               queue_pick(ST_SELECTED, ids[i+j], (j + 1 == cnt));
            return;
         end
      end
      queue_pick(ST_NONE, '0, 1'b1);
   endfunction

   // Monitor: table transactions feed the predictor, responses are checked
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         accepted <= accepted + 1;
         if (held_n < TABLES) begin
            held_id[held_n] = req_table_id;
            held_size[held_n] = req_size_bytes;
            held_n++;
         end else begin
            held_over = 1'b1;
         end
         if (req_last_table) begin
            predict_picks();
            held_n = 0;
            held_over = 1'b0;
            batches++;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         picks_seen <= picks_seen + 1;
         if (picks_q.size() == 0) begin
            $error("unexpected response: status %0d id %0h", rsp_status, rsp_chosen_id);
            errors++;
         end else begin
            pick_type want;
            want = picks_q.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_chosen_id !== want.id) begin
               $error("chosen_id: expected %0h, got %0h", want.id, rsp_chosen_id);
               errors++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_last_result);
               errors++;
            end
         end
      end
   end

   // Driver: one table per transaction, random gap after each unless in a burst
   int req_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (offered == accepted) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (tables_q.size() != 0) begin
            table_item_type t;
            t = tables_q.pop_front();
            req_table_id <= t.id;
            req_size_bytes <= t.size;
            req_last_table <= t.last;
            req_valid <= 1'b1;
            offered <= offered + 1;
            req_gap <= sender_burst ? 0 : $urandom_range(0, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall per response, one long hold, quiet stretches
   int rsp_stall;
   int rsp_seen_last;
   bit long_done;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
         rsp_seen_last <= 0;
      end else if (picks_seen != rsp_seen_last) begin
         rsp_seen_last <= picks_seen;
         if (picks_seen >= 40 && !long_done) begin
            long_done <= 1'b1;
            rsp_stall <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if ((picks_seen / 50) % 2 == 1) begin
            rsp_stall <= 0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any transaction
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_MIN_TABLES) min_cfg = value[7:0];
      else if (idx == REG_BUCKET_HIGH) high_cfg = value;
      else if (idx == REG_BUCKET_LOW) low_cfg = value;
   endtask

   task automatic set_buckets(input int min_t, input int high, input int low);
      write_csr(REG_MIN_TABLES, 16'(min_t));
      write_csr(REG_BUCKET_HIGH, 16'(high));
      write_csr(REG_BUCKET_LOW, 16'(low));
   endtask

   // Wait until every queued table is taken and every response has come
   task automatic drain();
      while (tables_q.size() != 0 || offered != accepted || picks_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic void push_table(input int id, input logic [SIZE_W-1:0] size,
                                      input bit last);
      table_item_type t;
      t.id = 16'(id);
      t.size = size;
      t.last = last;
      tables_q.insert(tables_q.size(), t);
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      return SIZE_W'({$urandom, $urandom}) >> $urandom_range(0, 47);
   endfunction

   // Batch of similar sizes with some outliers and ties
   function automatic void push_batch(input int n);
      logic [SIZE_W-1:0] base, sz;
      int                k;
      base = rand_size();
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 4) == 0) sz = rand_size();
         else sz = base - (((base >> 2) * $urandom_range(0, 3)) >> 2);
         push_table($urandom_range(0, 65535), sz, k == n - 1);
      end
   endfunction

   int n_pick;
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_table_id = '0;
      req_size_bytes = '0;
      req_last_table = 1'b0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      min_cfg = 8'd4;
      high_cfg = 16'd384;
      low_cfg = 16'd320;
      held_n = 0;
      held_over = 1'b0;
      offered = 0;
      accepted = 0;
      picks_seen = 0;
      errors = 0;
      batches = 0;
      sender_burst = 0;
      long_done = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, a plain bucket, ties, field extremes, too few
      push_table(1, 48'd100, 0);
      push_table(2, 48'd140, 0);
      push_table(3, 48'd120, 0);
      push_table(4, 48'd150, 1);
      push_table(16'hffff, 48'd7, 0);
      push_table(0, 48'd7, 0);
      push_table(5, 48'hffff_ffff_ffff, 0);
      push_table(6, 48'd7, 0);
      push_table(7, 48'd0, 1);
      push_table(8, 48'h8000_0000_0000, 0);
      push_table(9, 48'h5555_5555_5555, 1);
      drain();
      // Invalid multipliers: low equal to high, then low at exactly one
      set_buckets(2, 384, 384);
      push_batch(3);
      drain();
      write_csr(REG_BUCKET_LOW, 16'd256);
      push_batch(2);
      drain();
      // Minimum of zero and of one, widest multiplier, unknown register ignored
      set_buckets(0, 65535, 257);
      write_csr(REG_UNUSED, 16'hffff);
      push_batch(1);
      drain();
      write_csr(REG_MIN_TABLES, 16'd1);
      push_batch(3);
      drain();
      // Capacity exceeded
      set_buckets(4, 384, 320);
      push_batch(34);
      drain();

      // Random phases over several settings; sender pauses between them
      while (accepted < 240) begin
         case ($urandom_range(0, 5))
            0: set_buckets(0, 65535, 0);
            1: set_buckets(255, 384, 320);
            2: set_buckets(1, 258, 257);
            3: set_buckets(2, $urandom_range(257, 65535), $urandom_range(0, 1024));
            default: set_buckets($urandom_range(2, 8), $urandom_range(300, 800),
                                 $urandom_range(200, 400));
         endcase
         sender_burst = ($urandom_range(0, 2) == 0);
         repeat ($urandom_range(2, 5)) begin
            n_pick = $urandom_range(0, 15);
            if (n_pick == 0) push_batch($urandom_range(32, 35));
            else push_batch($urandom_range(1, 10));
         end
         drain();
      end

      $display("Ran %0d tables in %0d batches, %0d responses checked.",
               accepted, batches, picks_seen);
      $display("Covered overflow, too few, invalid multipliers and bucket picks.");
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
